// ----- design/smcr_pkg.sv -----
// shared types and constants for the cell request sort-and-merge unit
package smcr_pkg;

    localparam int MaxRecords = 64;
    localparam int IdxW = $clog2(MaxRecords);
    localparam int CntW = $clog2(MaxRecords + 1);

    typedef struct packed {
        logic [31:0] cell_id;
        logic [7:0]  channel_mask;
        logic [2:0]  request_class;
        logic        activate_flag;
        logic [15:0] priority_frac;
        logic [15:0] source_id;
        logic [47:0] deadline_ns;
        logic        batch_end;
    } req_t;

    typedef struct packed {
        logic [31:0] out_cell_id;
        logic [7:0]  out_channel_mask;
        logic [2:0]  out_class;
        logic        out_activate;
        logic [15:0] out_priority;
        logic [15:0] out_source_id;
        logic [47:0] out_deadline_ns;
        logic        overflowed;
        logic        last_result;
    } res_t;

    // one held record
    typedef struct packed {
        logic [31:0] id;
        logic [7:0]  mask;
        logic [2:0]  cls;
        logic        act;
        logic [15:0] prio;
        logic [15:0] src;
        logic [47:0] dl;
    } rec_t;

    localparam int RecW = $bits(rec_t);

    // controller to datapath
    typedef struct packed {
        logic           load_req;   // capture the accepted request
        logic           clr_scan;   // restart the scan pointer at zero
        logic           scan_step;  // advance the scan pointer
        logic           do_merge;   // write merged record at scan pointer
        logic           do_insert;  // write new record at scan pointer
        logic           do_shift;   // carry displaced record one slot up
        logic           set_ovf;
        logic           clr_batch;  // empty the store after the drain
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic at_end;   // scan pointer reached held count
        logic hit;      // entry at pointer has the request id
        logic beyond;   // entry at pointer id is greater than the request id
        logic full;
        logic last;     // request is the batch end
        logic drain_last;
    } dp_sts_t;

endpackage

// ----- design/sort_merge_cell_requests_unit.sv -----
// top level of the cell request sort-and-merge unit
// each request scans the held records up to its slot, a ram read and then a
// compare per entry, and an insert shifts every later record up one slot
// a new request is taken only in idle, after the previous one is finished
// drain: after the batch end each result comes from a registered ram read
// reset: rst_n async low clears held count, overflow flag and the controller
module sort_merge_cell_requests_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  smcr_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output smcr_pkg::res_t out_data
);
    import smcr_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;
    rec_t    rd_rec;
    logic    ovf;
    logic    rd_en;
    logic    out_last;

    // controller: walks the sorted store one entry per transaction step
    smcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_last (out_last),
        .sts      (sts),
        .cmd      (cmd),
        .rd_en    (rd_en)
    );

    // datapath: record ram, pointer, held count and merge arithmetic
    smcr_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (in_data),
        .cmd   (cmd),
        .rd_en (rd_en),
        .sts   (sts),
        .rd_rec(rd_rec),
        .ovf   (ovf)
    );

    // record fields of the result come straight from the registered ram read
    assign out_data = '{out_cell_id: rd_rec.id, out_channel_mask: rd_rec.mask,
                        out_class: rd_rec.cls, out_activate: rd_rec.act,
                        out_priority: rd_rec.prio, out_source_id: rd_rec.src,
                        out_deadline_ns: rd_rec.dl, overflowed: ovf,
                        last_result: out_last};
endmodule

// ----- design/smcr_ram.sv -----
// generic single-port ram with registered read
module smcr_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- design/smcr_datapath.sv -----
// record store, scan pointer and merge logic
module smcr_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  smcr_pkg::req_t  req,
    input  smcr_pkg::dp_cmd_t cmd,
    input  logic            rd_en,      // drain read request
    output smcr_pkg::dp_sts_t sts,
    output smcr_pkg::rec_t  rd_rec,
    output logic            ovf
);
    import smcr_pkg::*;

    req_t            req_reg;
    logic [CntW-1:0] ptr_reg, ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            ovf_reg, ovf_next;
    logic            we;
    rec_t            wrec, merged, fresh;
    logic [IdxW-1:0] addr;

    // next pointer addresses the ram (current one on a write); read data belongs to current pointer
    assign addr = ptr_next[IdxW-1:0];

    smcr_ram #(.Width(RecW), .Depth(MaxRecords)) u_ram (
        .clk  (clk),
        .we   (we),
        .addr (we ? ptr_reg[IdxW-1:0] : addr),
        .wdata(wrec),
        .rdata(rd_rec)
    );

    always_comb
    begin
        fresh = '{id: req_reg.cell_id, mask: req_reg.channel_mask,
                  cls: req_reg.request_class, act: req_reg.activate_flag,
                  prio: req_reg.priority_frac, src: req_reg.source_id,
                  dl: req_reg.deadline_ns};
        merged      = rd_rec;
        merged.mask = rd_rec.mask | req_reg.channel_mask;
        merged.act  = rd_rec.act | req_reg.activate_flag;
        if (req_reg.request_class < rd_rec.cls)
        begin
            merged.cls = req_reg.request_class;
        end
        if (req_reg.priority_frac > rd_rec.prio)
        begin
            merged.prio = req_reg.priority_frac;
            merged.src  = req_reg.source_id;
        end
        if (req_reg.deadline_ns < rd_rec.dl)
        begin
            merged.dl = req_reg.deadline_ns;
        end
        we   = cmd.do_merge | cmd.do_insert | cmd.do_shift;
        // a write also reads the old entry at that slot, so on a shift the
        // read data is the record displaced from the slot below
        wrec = cmd.do_merge ? merged : (cmd.do_insert ? fresh : rd_rec);
        ptr_next = ptr_reg;
        if (cmd.clr_scan)
        begin
            ptr_next = '0;
        end
        else if (cmd.scan_step || rd_en)
        begin
            ptr_next = ptr_reg + CntW'(1);
        end
        cnt_next = cnt_reg;
        if (cmd.clr_batch)
        begin
            cnt_next = '0;
        end
        else if (cmd.do_insert)
        begin
            cnt_next = cnt_reg + CntW'(1);
        end
        ovf_next = cmd.clr_batch ? 1'b0 : (ovf_reg | cmd.set_ovf);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

    assign sts.at_end     = (ptr_reg == cnt_reg);
    assign sts.hit        = (rd_rec.id == req_reg.cell_id);
    assign sts.beyond     = (rd_rec.id > req_reg.cell_id);
    assign sts.full       = (cnt_reg == CntW'(MaxRecords));
    assign sts.last       = req_reg.batch_end;
    assign sts.drain_last = (ptr_reg == cnt_reg - CntW'(1));
    assign ovf            = ovf_reg;
endmodule

// ----- design/smcr_ctrl.sv -----
// sequencing of scan, merge, insert, shift and drain
module smcr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_last,
    input  smcr_pkg::dp_sts_t sts,
    output smcr_pkg::dp_cmd_t cmd,
    output logic              rd_en
);
    import smcr_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,  // ram read of pointer entry in flight
        S_CMP   = 7'b0000100,
        S_SHIFT = 7'b0001000,
        S_DRD   = 7'b0010000,  // drain read in flight
        S_DOUT  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        rd_en      = 1'b0;
        in_ready   = (state_reg == S_IDLE);
        out_valid  = (state_reg == S_DOUT);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    cmd.clr_scan = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (sts.at_end || sts.beyond)
                begin
                    if (sts.full)
                    begin
                        cmd.set_ovf = 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        cmd.do_insert = 1'b1;
                        cmd.scan_step = 1'b1;
                        state_next    = sts.at_end ? S_DONE : S_SHIFT;
                    end
                end
                else if (sts.hit)
                begin
                    cmd.do_merge = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = S_READ;
                end
            end
            S_SHIFT:
            begin
                // read data is the record displaced from the slot below
                cmd.do_shift  = 1'b1;
                cmd.scan_step = 1'b1;
                if (sts.drain_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.clr_scan = 1'b1;
                state_next   = sts.last ? S_DRD : S_IDLE;
            end
            S_DRD:
            begin
                state_next = S_DOUT;
            end
            S_DOUT:
            begin
                if (out_ready)
                begin
                    if (sts.drain_last)
                    begin
                        cmd.clr_batch = 1'b1;
                        cmd.clr_scan  = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        state_next = S_DRD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_last = sts.drain_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule
